FILE: rtl/tsa_pkg.sv
// shared constants, symbol codes and queue entry type for the subdivision address block
package tsa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = FRAC_BITS + 1;
    localparam int PREC_MAX  = 16;
    localparam int PW        = 5;
    localparam int SW        = 4;
    localparam int MAX_SYMS  = PREC_MAX + 1;
    localparam int CNT_W     = 5;

    typedef logic [SW-1:0] t_sym;

    localparam t_sym SYM_T0  = 4'd0;
    localparam t_sym SYM_T1  = 4'd1;
    localparam t_sym SYM_T2  = 4'd2;
    localparam t_sym SYM_T3  = 4'd3;
    localparam t_sym SYM_P0  = 4'd4;
    localparam t_sym SYM_P1  = 4'd5;
    localparam t_sym SYM_P2  = 4'd6;
    localparam t_sym SYM_P3  = 4'd7;
    localparam t_sym SYM_BAD = 4'd8;

    localparam logic [PW-1:0] PREC_RESET = 5'd16;

    typedef struct packed {
        logic          bad;
        logic [CW-1:0] one;
        logic [CW-1:0] u;
        logic [CW-1:0] v;
        logic [CW-1:0] w;
    } t_entry;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

FILE: rtl/tsa_in_if.sv
// request channel carrying one point's barycentric coordinates
interface tsa_in_if;
    logic                  valid;
    logic                  ready;
    logic [tsa_pkg::CW-1:0] u_coord;
    logic [tsa_pkg::CW-1:0] v_coord;

    modport source (output valid, output u_coord, output v_coord, input ready);
    modport sink   (input valid, input u_coord, input v_coord, output ready);
endinterface

FILE: rtl/tsa_out_if.sv
// output channel carrying one address symbol and its last flag
interface tsa_out_if;
    logic                   valid;
    logic                   ready;
    tsa_pkg::t_sym          symbol;
    logic                   last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

FILE: rtl/tsa_front.sv
// front end: precision register, rounding and sum check, pushes work into the queue
module tsa_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tsa_pkg::PW-1:0]    i_cfg_wdata,
    tsa_in_if.sink                    i_pt,
    input  tsa_pkg::t_q_status        i_q_status,
    output logic                      o_push,
    output tsa_pkg::t_entry           o_entry
);

    logic [tsa_pkg::PW-1:0]   r_precision;
    logic [tsa_pkg::PW-1:0]   p;
    logic [tsa_pkg::CW-1:0]   one;
    logic [tsa_pkg::CW-1:0]   u_rnd;
    logic [tsa_pkg::CW-1:0]   v_rnd;
    logic [tsa_pkg::CW:0]     uv_sum;

    function automatic logic [tsa_pkg::CW-1:0] round_coord(
        input logic [tsa_pkg::CW-1:0] c,
        input logic [tsa_pkg::PW-1:0] prec
    );
        logic [3:0]              d;
        logic [tsa_pkg::CW-1:0]  t;
        logic [tsa_pkg::CW-1:0]  r;
        if (prec == tsa_pkg::PW'(tsa_pkg::FRAC_BITS)) begin
            r = c;
        end else begin
            // shift to one bit below the kept lsb, then add that bit
            d = 4'(tsa_pkg::PW'(tsa_pkg::FRAC_BITS - 1) - prec);
            t = c >> d;
            r = (t >> 1) + tsa_pkg::CW'(t[0]);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision <= tsa_pkg::PREC_RESET;
        end else if (i_cfg_we) begin
            r_precision <= i_cfg_wdata;
        end
    end

    always_comb begin
        p = (r_precision > tsa_pkg::PW'(tsa_pkg::PREC_MAX)) ?
            tsa_pkg::PW'(tsa_pkg::PREC_MAX) : r_precision;
        one    = tsa_pkg::CW'(1) << p;
        u_rnd  = round_coord(i_pt.u_coord, p);
        v_rnd  = round_coord(i_pt.v_coord, p);
        uv_sum = {1'b0, u_rnd} + {1'b0, v_rnd};

        o_entry.bad = uv_sum > {1'b0, one};
        o_entry.one = one;
        o_entry.u   = u_rnd;
        o_entry.v   = v_rnd;
        o_entry.w   = one - u_rnd - v_rnd;
    end

    assign i_pt.ready = !i_q_status.full;
    assign o_push     = i_pt.valid && !i_q_status.full;

endmodule

FILE: rtl/tsa_queue.sv
// small queue of classified points between front end and walker
module tsa_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tsa_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output tsa_pkg::t_entry     o_entry,
    output tsa_pkg::t_q_status  o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    tsa_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [NW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign do_push = i_push && (r_count != NW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    assign o_entry        = r_mem[r_rptr];
    assign o_status.full  = (r_count == NW'(DEPTH));
    assign o_status.valid = (r_count != '0);

endmodule

FILE: rtl/tsa_walk.sv
// back end: walks the subdivision one level per cycle into the output register unless the output stalls
module tsa_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsa_pkg::t_entry     i_entry,
    input  tsa_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    tsa_out_if.source           o_sym
);

    logic                        r_busy;
    logic                        r_bad;
    logic [tsa_pkg::CW-1:0]      r_one;
    logic [tsa_pkg::CW-1:0]      r_u;
    logic [tsa_pkg::CW-1:0]      r_v;
    logic [tsa_pkg::CW-1:0]      r_w;
    logic [tsa_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_out_valid;
    tsa_pkg::t_sym               r_symbol;
    logic                        r_last;

    logic                        adv;
    logic                        stop;
    tsa_pkg::t_sym               sym;
    logic [tsa_pkg::CW:0]        u2;
    logic [tsa_pkg::CW:0]        v2;
    logic [tsa_pkg::CW:0]        w2;
    logic [tsa_pkg::CW:0]        one2;
    logic [tsa_pkg::CW:0]        nu;
    logic [tsa_pkg::CW:0]        nv;
    logic [tsa_pkg::CW:0]        nw;

    assign adv   = r_busy && (!r_out_valid || o_sym.ready);
    assign o_pop = !r_busy && i_q_status.valid;

    always_comb begin
        u2   = {r_u, 1'b0};
        v2   = {r_v, 1'b0};
        w2   = {r_w, 1'b0};
        one2 = {1'b0, r_one};
        nu   = u2;
        nv   = v2;
        nw   = w2;
        stop = 1'b1;
        if (r_bad) begin
            sym = tsa_pkg::SYM_BAD;
        end else if (r_u == r_one) begin
            sym = tsa_pkg::SYM_P0;
        end else if (r_v == r_one) begin
            sym = tsa_pkg::SYM_P1;
        end else if (r_w == r_one) begin
            sym = tsa_pkg::SYM_P2;
        end else if (r_u == r_v && r_v == r_w) begin
            sym = tsa_pkg::SYM_P3;
        end else begin
            stop = 1'b0;
            if (u2 >= one2) begin
                sym = tsa_pkg::SYM_T0;
                nu  = u2 - one2;
            end else if (v2 >= one2) begin
                sym = tsa_pkg::SYM_T1;
                nv  = v2 - one2;
            end else if (w2 >= one2) begin
                sym = tsa_pkg::SYM_T2;
                nw  = w2 - one2;
            end else begin
                // middle child flips orientation
                sym = tsa_pkg::SYM_T3;
                nu  = one2 - w2;
                nv  = one2 - u2;
                nw  = one2 - v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (adv) begin
                // cap guards the walk length even though it always ends in time
                if (stop || r_cnt == tsa_pkg::CNT_W'(tsa_pkg::MAX_SYMS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + tsa_pkg::CNT_W'(1);
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_sym.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bad <= i_entry.bad;
            r_one <= i_entry.one;
            r_u   <= i_entry.u;
            r_v   <= i_entry.v;
            r_w   <= i_entry.w;
        end else if (adv) begin
            r_u <= nu[tsa_pkg::CW-1:0];
            r_v <= nv[tsa_pkg::CW-1:0];
            r_w <= nw[tsa_pkg::CW-1:0];
        end
        if (adv) begin
            r_symbol <= sym;
            r_last   <= stop || (r_cnt == tsa_pkg::CNT_W'(tsa_pkg::MAX_SYMS - 1));
        end
    end

    assign o_sym.valid  = r_out_valid;
    assign o_sym.symbol = r_symbol;
    assign o_sym.last   = r_last;

endmodule

FILE: rtl/triangle_subdivision_address.sv
// top level: an accepted request is queued and loaded into the walker once it is idle;
// a point of n symbols (n = 1 to precision + 1) holds the walker for the load from the
// queue, then one subdivision level per cycle while the output is not stalled
// the queue (two entries by default) lets new points be taken while the walker is still busy
// reset is synchronous active low: queue and walker empty, precision back to 16
module triangle_subdivision_address #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [tsa_pkg::PW-1:0]  i_cfg_wdata,
    tsa_in_if.sink                  i_pt,
    tsa_out_if.source               o_sym
);

    tsa_pkg::t_entry    push_entry;
    tsa_pkg::t_entry    head_entry;
    tsa_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    tsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (i_pt),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    tsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    tsa_walk u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_sym      (o_sym)
    );

endmodule
